// File: design/sha256_pkg.sv
// Shared types, constants and tables for the single-block SHA-256 hash core.
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } sha256_state_type;

   typedef logic [7:0][31:0]  sha256_vars_type;
   typedef logic [15:0][31:0] sha256_window_type;

   localparam logic [5:0] MAX_BYTES  = 6'd55;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// File: design/sha256_single_block_hash_core.sv
// Single-block SHA-256 core: byte packing, padding, 64 rounds and digest output.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    message_byte, byte_valid, last
//   rsp      out        rsp_valid/stall    digest_word, too_long, last_word
//
// A byte word is taken each cycle while no hash is in progress.
// A word with last starts a load state, the rounds on the shared round
// unit and a finalize state, then eight digest words, one per rsp handshake.
// req_stall stays high from the last word until the eighth digest word leaves.
// Reset is synchronous and clears the byte store, counters and state.
module sha256_single_block_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_too_long,
   output logic        rsp_last_word
);

   sha256_pkg::sha256_state_type  state_ff;
   sha256_pkg::sha256_state_type  state_in;
   logic [3:0][7:0]               msg_ff [14];
   logic [5:0]                    count_ff;
   logic                          overflow_ff;
   logic [5:0]                    round_ff;
   logic [2:0]                    out_cnt_ff;
   sha256_pkg::sha256_vars_type   vars_ff;
   sha256_pkg::sha256_window_type window_ff;
   sha256_pkg::sha256_window_type load_words;
   sha256_pkg::sha256_vars_type   vars_next;
   logic [31:0]                   sched_next;
   logic                          req_take;
   logic                          rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   assign req_stall       = (state_ff != sha256_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha256_pkg::ST_OUT);
   assign rsp_digest_word = vars_ff[0];
   assign rsp_too_long    = overflow_ff;
   assign rsp_last_word   = (out_cnt_ff == sha256_pkg::LAST_WORD);

   sha256_round u_round (
      .vars       (vars_ff),
      .window     (window_ff),
      .round_k    (sha256_pkg::ROUND_K[round_ff]),
      .vars_next  (vars_next),
      .sched_next (sched_next)
   );

   // pad the stored bytes and append the bit length
   always_comb begin
      for (int i = 0; i < 14; i++) begin
         load_words[i] = msg_ff[i];
         if (count_ff[5:2] == 4'(i)) begin
            load_words[i][{2'd3 - count_ff[1:0], 3'd0} +: 8] = sha256_pkg::PAD_BYTE;
         end
      end
      load_words[14] = '0;
      load_words[15] = {23'd0, count_ff, 3'd0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_take && req_last) begin
               state_in = sha256_pkg::ST_LOAD;
            end
         end
         sha256_pkg::ST_LOAD: begin
            state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = sha256_pkg::ST_FINAL;
            end
         end
         sha256_pkg::ST_FINAL: begin
            state_in = sha256_pkg::ST_OUT;
         end
         sha256_pkg::ST_OUT: begin
            if (rsp_take && rsp_last_word) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 14; i++) begin
            msg_ff[i] <= '0;
         end
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         round_ff    <= '0;
         out_cnt_ff  <= '0;
      end else begin
         unique case (state_ff)
            sha256_pkg::ST_IDLE: begin
               if (req_take && req_byte_valid) begin
                  if (count_ff < sha256_pkg::MAX_BYTES) begin
                     msg_ff[count_ff[5:2]][2'd3 - count_ff[1:0]] <= req_message_byte;
                     count_ff <= count_ff + 6'd1;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
               end
            end
            sha256_pkg::ST_LOAD: begin
               for (int i = 0; i < 14; i++) begin
                  msg_ff[i] <= '0;
               end
               count_ff <= '0;
               round_ff <= '0;
            end
            sha256_pkg::ST_ROUND: begin
               round_ff <= round_ff + 6'd1;
            end
            sha256_pkg::ST_FINAL: begin
               out_cnt_ff <= '0;
            end
            sha256_pkg::ST_OUT: begin
               if (rsp_take) begin
                  out_cnt_ff <= out_cnt_ff + 3'd1;
                  if (rsp_last_word) begin
                     overflow_ff <= 1'b0;
                  end
               end
            end
            default: begin
               round_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         sha256_pkg::ST_LOAD: begin
            window_ff <= load_words;
            for (int i = 0; i < 8; i++) begin
               vars_ff[i] <= sha256_pkg::INIT_HASH[i];
            end
         end
         sha256_pkg::ST_ROUND: begin
            vars_ff <= vars_next;
            for (int i = 0; i < 15; i++) begin
               window_ff[i] <= window_ff[i + 1];
            end
            window_ff[15] <= sched_next;
         end
         sha256_pkg::ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               vars_ff[i] <= overflow_ff ? 32'd0 : sha256_pkg::INIT_HASH[i] + vars_ff[i];
            end
         end
         sha256_pkg::ST_OUT: begin
            if (rsp_take) begin
               for (int i = 0; i < 7; i++) begin
                  vars_ff[i] <= vars_ff[i + 1];
               end
            end
         end
         default: begin
            vars_ff <= vars_ff;
         end
      endcase
   end

   a_last_starts_load: assert property (@(posedge clock) disable iff (reset)
      req_take && req_last |=> state_ff == sha256_pkg::ST_LOAD)
      else $error("last word did not start a hash");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sha256_pkg::MAX_BYTES)
      else $error("byte count past block limit");

   a_too_long_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_digest_word == 32'd0)
      else $error("too_long digest word not zero");

   a_round_idle_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256_pkg::ST_IDLE |-> round_ff == 6'd0)
      else $error("round counter not cleared");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_word |=> count_ff == 6'd0 && !overflow_ff
         && state_ff == sha256_pkg::ST_IDLE)
      else $error("message state not cleared after digest");

endmodule

// File: design/sha256_round.sv
// One SHA-256 compression round and the next message schedule word.
module sha256_round (
   input  sha256_pkg::sha256_vars_type   vars,
   input  sha256_pkg::sha256_window_type window,
   input  logic [31:0]                   round_k,
   output sha256_pkg::sha256_vars_type   vars_next,
   output logic [31:0]                   sched_next
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] big_s0;
   logic [31:0] big_s1;
   logic [31:0] ch;
   logic [31:0] maj;
   logic [31:0] t_one;
   logic [31:0] t_two;
   logic [31:0] small_s0;
   logic [31:0] small_s1;

   always_comb begin
      big_s1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
      big_s0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
      ch     = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
      maj    = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
      t_one  = vars[7] + big_s1 + ch + round_k + window[0];
      t_two  = big_s0 + maj;

      vars_next[7] = vars[6];
      vars_next[6] = vars[5];
      vars_next[5] = vars[4];
      vars_next[4] = vars[3] + t_one;
      vars_next[3] = vars[2];
      vars_next[2] = vars[1];
      vars_next[1] = vars[0];
      vars_next[0] = t_one + t_two;

      small_s0   = rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3);
      small_s1   = rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10);
      sched_next = small_s1 + window[9] + small_s0 + window[0];
   end

endmodule

// File: test/sha256_digest_checker.sv
// Checker for the SHA-256 core: predicts digest words from accepted byte words and compares.
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_too_long,
   input  logic        rsp_last_word,
   output int          mismatch_count,
   output int          digest_words_pending,
   output int          digest_words_checked
);

   typedef logic [15:0][31:0] block_words_type;
   typedef logic [7:0][31:0]  hash_words_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        too_long;
      logic        last_word;
   } digest_word_type;

   localparam logic [5:0] BLOCK_BYTE_LIMIT = 6'd55;
   localparam logic [7:0] PAD_MARK         = 8'h80;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   block_words_type msg_block;
   logic [5:0]      stored_bytes;
   logic            byte_dropped;
   digest_word_type expected_digest_words [$];
   int              error_count;
   int              checked_count;

   assign mismatch_count       = error_count;
   assign digest_words_checked = checked_count;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic hash_words_type sha256_compress(input block_words_type blk);
      block_words_type w;
      hash_words_type  v;
      hash_words_type  digest;
      logic [31:0]     t1, t2, s0, s1, x2, x15;
      int              r;
      int              i;
      w = blk;
      for (i = 0; i < 8; i++) v[i] = IV[i];
      for (r = 0; r < 64; r++) begin
         if (r >= 16) begin
            x2  = w[(r - 2) & 15];
            x15 = w[(r - 15) & 15];
            s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
            s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
            w[r & 15] = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r & 15];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7:1] = v[6:0];
         v[4]   = v[4] + t1;
         v[0]   = t1 + t2;
      end
      for (i = 0; i < 8; i++) digest[i] = IV[i] + v[i];
      return digest;
   endfunction

   task automatic pack_byte(input logic [7:0] b);
      msg_block[stored_bytes[5:2]] = msg_block[stored_bytes[5:2]]
                                   | ({24'b0, b} << (24 - 8 * stored_bytes[1:0]));
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : track
      digest_word_type want;
      hash_words_type  digest;
      int              j;
      if (reset) begin
         msg_block    = '0;
         stored_bytes = '0;
         byte_dropped = 1'b0;
         expected_digest_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_digest_words.size() == 0) begin
               report_mismatch("digest word with none due", rsp_digest_word, 32'd0);
            end else begin
               want = expected_digest_words.pop_front();
               if (rsp_digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_digest_word, want.digest_word);
               if (rsp_too_long !== want.too_long)
                  report_mismatch("too_long", {31'b0, rsp_too_long}, {31'b0, want.too_long});
               if (rsp_last_word !== want.last_word)
                  report_mismatch("last_word", {31'b0, rsp_last_word}, {31'b0, want.last_word});
               checked_count++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_byte_valid) begin
               if (stored_bytes < BLOCK_BYTE_LIMIT) begin
                  pack_byte(req_message_byte);
                  stored_bytes++;
               end else begin
                  byte_dropped = 1'b1;
               end
            end
            if (req_last) begin
               pack_byte(PAD_MARK);
               msg_block[15] = {23'b0, stored_bytes, 3'b000};
               digest = sha256_compress(msg_block);
               for (j = 0; j < 8; j++) begin
                  want.digest_word = byte_dropped ? 32'd0 : digest[j];
                  want.too_long    = byte_dropped;
                  want.last_word   = (j == 7);
                  expected_digest_words = {expected_digest_words, want};
               end
               msg_block    = '0;
               stored_bytes = '0;
               byte_dropped = 1'b0;
            end
         end
      end
      digest_words_pending <= expected_digest_words.size();
   end

endmodule

// File: test/sha256_single_block_hash_core_test.sv
// Top of the SHA-256 core test: clock, reset, byte word stimulus, receiver stalls and verdict.
module sha256_single_block_hash_core_test;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_message_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic        rsp_too_long;
   logic        rsp_last_word;

   int mismatch_count;
   int digest_words_pending;
   int digest_words_checked;

   int words_sent      = 0;
   int messages_sent   = 0;
   int long_messages   = 0;
   bit req_gaps_on     = 1'b1;
   bit rsp_gaps_on     = 1'b1;
   bit quiet_tail      = 1'b0;

   sha256_single_block_hash_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_byte (req_message_byte),
      .req_byte_valid   (req_byte_valid),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_word    (rsp_last_word)
   );

   sha256_digest_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_message_byte     (req_message_byte),
      .req_byte_valid       (req_byte_valid),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_digest_word      (rsp_digest_word),
      .rsp_too_long         (rsp_too_long),
      .rsp_last_word        (rsp_last_word),
      .mismatch_count       (mismatch_count),
      .digest_words_pending (digest_words_pending),
      .digest_words_checked (digest_words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic offer_word(input logic [7:0] b, input logic bv, input logic fin);
      if (req_gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_byte <= b;
      req_byte_valid   <= bv;
      req_last         <= fin;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (words_sent >= 290) quiet_tail = 1'b1;
   endtask

   task automatic send_message(input int len);
      bit fold;
      int i;
      fold = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len - fold; i++) begin
         if ($urandom_range(0, 9) == 0) offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         offer_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      offer_word(8'($urandom_range(0, 255)), fold, 1'b1);
      messages_sent++;
      if (len > 55) long_messages++;
   endtask

   // receiver: one long hold-off first, then random stall bursts
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_gaps_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int sel;
      int len;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_message_byte <= 8'h00;
      req_byte_valid   <= 1'b0;
      req_last         <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty message, "abc" closed by a last without a byte, then three short messages mixing in words without a byte
      offer_word(8'h00, 1'b0, 1'b1);
      offer_word(8'h61, 1'b1, 1'b0);
      offer_word(8'h62, 1'b1, 1'b0);
      offer_word(8'h63, 1'b1, 1'b0);
      offer_word(8'hff, 1'b0, 1'b1);
      offer_word(8'hff, 1'b0, 1'b0);
      offer_word(8'hff, 1'b1, 1'b1);
      offer_word(8'h00, 1'b1, 1'b0);
      offer_word(8'haa, 1'b0, 1'b0);
      offer_word(8'h80, 1'b1, 1'b1);
      offer_word(8'h55, 1'b0, 1'b0);
      offer_word(8'h00, 1'b1, 1'b1);
      messages_sent += 5;

      send_message(55);
      send_message(56);

      while (words_sent < 360) begin
         sel = $urandom_range(0, 9);
         if (sel < 5)      len = $urandom_range(0, 12);
         else if (sel < 8) len = $urandom_range(13, 53);
         else if (sel < 9) len = $urandom_range(54, 56);
         else              len = $urandom_range(57, 64);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         send_message(len);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (digest_words_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Run sent %0d byte words in %0d messages, %0d of them over the 55-byte limit.",
               words_sent, messages_sent, long_messages);
      $display("%0d digest words compared against the predicted hash.", digest_words_checked);
      if (mismatch_count == 0 && digest_words_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
